// File: rtl/sha_pkg.sv
// SHA-256 hasher package: item types, round constants, initial hash values.
// Used by every module of the hasher; no dependencies.
package sha_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] init_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] kround(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k[idx];
    endfunction

endpackage

// File: rtl/sha_queue.sv
// Short item queue between front and back of the SHA-256 hasher.
// Depends on sha_pkg.
module sha_queue #(
    parameter int DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sha_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output sha_pkg::t_in_item o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_pkg::t_in_item r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic wr, rd;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// File: rtl/sha_core.sv
// SHA-256 back end: block buffer, padding sequencer, one round per cycle,
// digest output register. Depends on sha_pkg.
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sha_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output sha_pkg::t_out_item o_item
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_ADD   = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_CLEAR = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_fill;
    logic [60:0] r_len;
    logic [5:0]  r_rnd;
    logic        r_final;
    logic        r_spill;
    logic [2:0]  r_oidx;
    logic        r_ovalid;
    sha_pkg::t_out_item r_oitem;

    logic [31:0] w_word, t1, t2, s0, s1, wnext, e, a;
    logic [7:0]  pad_byte;
    logic [63:0] bits;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign bits = {r_len, 3'b000};
    // byte written while padding: zeros, then length bytes in the last eight
    // of the block that carries the length
    always_comb begin
        if (r_fill >= 6'd56 && !r_spill) begin
            pad_byte = bits[8*(7 - r_fill[2:0]) +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign w_word = r_w[0];
    assign e  = r_v[4];
    assign a  = r_v[0];
    assign t1 = r_v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + sha_pkg::kround(r_rnd) + w_word;
    assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
    assign wnext = r_w[0] + s0 + r_w[9] + s1;

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_item.cmd == sha_pkg::CMD_FINISH) begin
                        n_state = (r_fill == 6'd63) ? ST_ROUND : ST_PAD;
                    end else if (r_fill == 6'd63) begin
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_PAD:   n_state = (r_fill == 6'd63) ? ST_ROUND : ST_PAD;
            ST_ROUND: n_state = (r_rnd == 6'd63) ? ST_ADD : ST_ROUND;
            ST_ADD: begin
                if (!r_final) begin
                    n_state = ST_IDLE;
                end else if (r_spill) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT:  n_state = (r_oidx == 3'd7 && !r_ovalid) ? ST_CLEAR : ST_EMIT;
            ST_CLEAR: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // shift one byte into the schedule window
    task automatic push_byte(input logic [7:0] b);
        r_w[r_fill[5:2]] <= {r_w[r_fill[5:2]][23:0], b};
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_len    <= '0;
            r_rnd    <= '0;
            r_final  <= 1'b0;
            r_spill  <= 1'b0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::init_word(3'(i));
            end
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_item.cmd == sha_pkg::CMD_FINISH) begin
                            push_byte(sha_pkg::PAD_BYTE);
                            r_final <= 1'b1;
                            r_fill  <= r_fill + 1'b1;
                            // a full second block is needed past 55 pending bytes
                            r_spill <= (r_fill >= 6'd56);
                            if (r_fill == 6'd63) begin
                                r_rnd <= '0;
                                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            end
                        end else begin
                            push_byte(i_item.data_byte);
                            r_fill <= r_fill + 1'b1;
                            r_len  <= r_len + 1'b1;
                            if (r_fill == 6'd63) begin
                                r_rnd <= '0;
                                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            end
                        end
                    end
                end
                ST_PAD: begin
                    push_byte(pad_byte);
                    r_fill <= r_fill + 1'b1;
                    if (r_fill == 6'd63) begin
                        r_rnd <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wnext;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= e;
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= a;
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 1'b1;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oidx <= '0;
                    // after a spilled pad the next block carries the length
                    if (r_final) begin
                        r_spill <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_oitem.digest_word <= r_h[r_oidx];
                        r_oitem.word_index  <= r_oidx;
                        r_oitem.last_word   <= (r_oidx == 3'd7);
                        if (r_oidx != 3'd7) r_oidx <= r_oidx + 1'b1;
                    end
                end
                ST_CLEAR: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_word(3'(i));
                    r_fill  <= '0;
                    r_len   <= '0;
                    r_final <= 1'b0;
                    r_spill <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule

// File: rtl/sha256_stream_hasher_top.sv
// SHA-256 stream hasher, top level: front queue and compression back end.
// Depends on sha_pkg, sha_queue, sha_core.
//
// Usage: drive one item per handshake on the input channel (i_valid/o_ready).
// cmd absorb adds data_byte to the message; cmd finish pads the message,
// runs the last block(s) and returns eight digest items on the output channel
// (o_valid/i_ready), word 0 first, last_word set on word 7.
// Throughput: the core takes one absorb item per cycle until a block fills;
// each full block is then compressed in 64 rounds and the final additions,
// and the core takes no items until that is done.
// The queue registers each item before the core sees it. A finish runs the
// padding bytes and one or two compressions before the first digest item
// appears; the core loads each further digest item only once the one before
// has been taken, and afterwards restores the hash state. The queue keeps
// accepting items meanwhile until it is full.
// Reset (synchronous, active low) returns the hash words, counters and
// queue to their initial state. A stalled receiver holds the digest item in
// the output register; the core waits and the queue fills behind it.
// After the last digest word the core restores the initial hash state.
module sha256_stream_hasher_top #(
    parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sha_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output sha_pkg::t_out_item o_item
);
    logic              q_valid, q_ready;
    sha_pkg::t_in_item q_item;

    // hold incoming items while the core compresses
    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready, .i_item,
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    sha_core u_core (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid, .i_ready, .o_item
    );

    // digest words leave in order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_item.last_word |=>
            !o_valid || o_item.word_index == $past(o_item.word_index) + 3'd1)
        else $error("digest word order broken");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.last_word == (o_item.word_index == 3'd7)))
        else $error("last_word flag mismatch");
endmodule
